[rtl/oav_pkg.sv]
// Shared types and constants of the overlapping Allan variance core.
// No dependencies; oav_div, the core and the bench refer to it by scoped names.
`timescale 1ns / 1ps
package oav_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MAX_TAU     = 16;
  localparam int MIN_SAMPLES = 4;

  // n / 3 as (n * RECIP3) >> RECIP3_SH, exact over the sample count range
  localparam int RECIP3    = 21846;
  localparam int RECIP3_SH = 16;
  localparam int MMAX_W    = CNT_W - 1;

  localparam int SUM_W      = 28;              // cluster sum
  localparam int SQ_W       = 2 * SUM_W;       // squared difference
  localparam int ACC_W      = SQ_W + CNT_W;    // sum of squares
  localparam int FRAC_W     = 16;
  localparam int DIVIDEND_W = ACC_W + FRAC_W;
  localparam int DIVISOR_W  = 2 * ADDR_W + ADDR_W + 1;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic CFG_TAU_LIMIT = 1'b0;
  localparam logic CFG_PERIOD    = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] cluster_size;
    logic [47:0] tau;
    logic [63:0] variance;
    logic [31:0] deviation;
    logic        last_result;
  } out_item_t;

endpackage

[rtl/oav_div.sv]
// Restoring divider, one quotient bit per cycle, quotient saturates to 64 bits.
// Depends on oav_pkg for operand widths.
`timescale 1ns / 1ps
module oav_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [oav_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [oav_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [63:0]                      quotient
);

  localparam int STEP_W = $clog2(oav_pkg::DIVIDEND_W + 1);

  logic                            busy_r;
  logic                            done_r;
  logic [STEP_W-1:0]               cnt_r;
  logic [oav_pkg::DIVISOR_W-1:0]   d_r;
  logic [oav_pkg::DIVISOR_W-1:0]   rem_r;
  logic [oav_pkg::DIVIDEND_W-1:0]  quo_r;
  logic [oav_pkg::DIVISOR_W:0]     shifted;
  logic                            qbit;

  assign shifted = {rem_r, quo_r[oav_pkg::DIVIDEND_W-1]};
  assign qbit    = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        d_r    <= divisor;
        rem_r  <= '0;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= qbit ? oav_pkg::DIVISOR_W'(shifted - {1'b0, d_r})
                      : oav_pkg::DIVISOR_W'(shifted);
        quo_r <= {quo_r[oav_pkg::DIVIDEND_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(oav_pkg::DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = (|quo_r[oav_pkg::DIVIDEND_W-1:64]) ? '1 : quo_r[63:0];

endmodule

[rtl/oav_sqrt.sv]
// Iterative integer square root of a 64-bit radicand, one result bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
module oav_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= radicand;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

[rtl/overlapping_allan_variance_core.sv]
// Overlapping Allan variance core: sample store, sequencer, shared divider/sqrt.
// Depends on oav_pkg, oav_div and oav_sqrt.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one signed sample per beat, one
//    beat per cycle while loading. Up to 4096 samples are kept; more are dropped.
//  - The beat with last_sample set starts the analysis; in_stall stays high
//    until the summary (or error) result has been handed to the output register.
//  - Output channel (out_valid/out_stall/out_data): one point per cluster size,
//    then a summary with last_result set; fewer than 4 samples give one error.
//  - Per cluster size m with T = N-2m+1 terms the sequencer forms the initial
//    sums, runs the squared-difference loop (one store read port, one
//    multiplier), waits on the divider (85 quotient bits) and then on the
//    square root unit (32 result bits), which is skipped when the variance is
//    too large for it. Setup states come first.
//  - A stalled receiver holds the current result; the sequencer waits for the
//    output register to free before it writes the next one.
//  - cfg_* writes tau_count_limit (index 0) and sample_period (index 1); ready
//    is always high. Writes are expected only while the block is idle.
//  - Reset (rst_n low, synchronous) clears the sample count, the minimum
//    tracking and the handshake state; the store contents are not cleared.
`timescale 1ns / 1ps
module overlapping_allan_variance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oav_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output oav_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = oav_pkg::ADDR_W;
  localparam int CW = oav_pkg::CNT_W;
  localparam int MW = oav_pkg::MMAX_W;
  localparam int SW = oav_pkg::SUM_W;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_RANGE, S_TAU, S_INIT_A, S_INIT_B, S_INIT_C,
    S_SQ, S_R1, S_R2, S_R3, S_DIVM, S_DIVD, S_DIVW, S_SQRTW,
    S_EMIT, S_SUM, S_ERR
  } state_t;

  state_t state_r;

  logic [4:0]  tau_limit_r;
  logic [31:0] period_r;

  logic signed [15:0] mem [oav_pkg::MAX_SAMPLES];
  logic signed [15:0] rdata_r;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic [CW-1:0]  count_r;
  logic [MW-1:0]  mmax_r;
  logic [4:0]     ntau_r;
  logic [4:0]     i_r;
  logic [AW-1:0]  m_r;
  logic [AW-1:0]  j_r;
  logic [AW-1:0]  t_r;
  logic [AW-1:0]  terms_r;
  logic signed [SW-1:0] sa_r;
  logic signed [SW-1:0] sb_r;
  logic signed [15:0]   x0_r;
  logic signed [15:0]   xm_r;
  logic [SW-1:0]        ad_r;
  logic [oav_pkg::SQ_W-1:0]  sq_r;
  logic [oav_pkg::ACC_W-1:0] acc_r;
  logic [2*AW-1:0] mm_r;
  logic [47:0]     tau_r;
  logic [63:0]     var_r;
  logic [31:0]     dev_r;
  logic            found_r;
  logic [31:0]     min_dev_r;
  logic [47:0]     tau_min_r;

  logic                       out_valid_r;
  oav_pkg::out_item_t         out_data_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic [27:0]          mmax_prod;
  logic [MW-1:0]        mmax_cl;
  logic [4:0]           lim;
  logic [4:0]           ntau_a;
  logic [4:0]           ntau_b;
  logic [AW-1:0]        m_cl;
  logic signed [SW:0]   diff;
  logic                 div_start;
  logic                 div_done;
  logic [63:0]          div_q;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [31:0]          sqrt_root;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && (state_r inside {S_EMIT, S_SUM, S_ERR});
  assign wr_en     = in_acc && (count_r < CW'(oav_pkg::MAX_SAMPLES));

  assign mmax_prod = 28'(count_r) * 28'(oav_pkg::RECIP3);
  assign mmax_cl   = (mmax_r < MW'(2)) ? MW'(2) : mmax_r;
  assign lim       = (tau_limit_r < 5'd2) ? 5'd2 : tau_limit_r;
  assign ntau_a    = (MW'(lim) > mmax_cl) ? 5'(mmax_cl) : lim;
  assign ntau_b    = (ntau_a > 5'(oav_pkg::MAX_TAU)) ? 5'(oav_pkg::MAX_TAU) : ntau_a;
  assign m_cl      = (m_r > AW'(mmax_r)) ? AW'(mmax_r) : m_r;
  assign diff      = (SW+1)'(sb_r) - (SW+1)'(sa_r);

  // store read address follows the sequencer; data shows up one state later
  always_comb begin
    case (state_r)
      S_INIT_A: rd_addr = j_r;
      S_INIT_B: rd_addr = m_r + j_r;
      S_SQ:     rd_addr = t_r;
      S_R1:     rd_addr = t_r + m_r;
      S_R2:     rd_addr = t_r + {m_r[AW-2:0], 1'b0};
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_data.sample;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_limit_r <= 5'd16;
      period_r    <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        oav_pkg::CFG_TAU_LIMIT: tau_limit_r <= cfg_data[4:0];
        oav_pkg::CFG_PERIOD:    period_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign div_start  = (state_r == S_DIVD);
  assign sqrt_start = (state_r == S_DIVW) && div_done && (div_q[63:48] == '0);

  oav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({acc_r, oav_pkg::FRAC_W'(0)}),
    .divisor  ({oav_pkg::DIVISOR_W'(mm_r) * oav_pkg::DIVISOR_W'(terms_r)}
               << 1),
    .done     (div_done),
    .quotient (div_q)
  );

  oav_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({div_q[47:0], 16'd0}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      min_dev_r   <= '1;
      tau_min_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (wr_en) count_r <= count_r + 1'b1;
            if (in_data.last_sample) state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          mmax_r  <= mmax_prod[oav_pkg::RECIP3_SH +: MW];
          state_r <= (count_r < CW'(oav_pkg::MIN_SAMPLES)) ? S_ERR : S_RANGE;
        end
        S_RANGE: begin
          mmax_r  <= mmax_cl;
          ntau_r  <= ntau_b;
          m_r     <= AW'(1);
          i_r     <= '0;
          state_r <= S_TAU;
        end
        S_TAU: begin
          m_r     <= m_cl;
          terms_r <= AW'(count_r - {m_cl, 1'b0} + 1'b1);
          sa_r    <= '0;
          sb_r    <= '0;
          j_r     <= '0;
          t_r     <= '0;
          acc_r   <= '0;
          state_r <= S_INIT_A;
        end
        S_INIT_A: state_r <= S_INIT_B;
        S_INIT_B: begin
          sa_r    <= sa_r + SW'(rdata_r);
          state_r <= S_INIT_C;
        end
        S_INIT_C: begin
          sb_r <= sb_r + SW'(rdata_r);
          if (j_r + 1'b1 == m_r) begin
            state_r <= S_SQ;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_INIT_A;
          end
        end
        S_SQ: begin
          ad_r    <= diff[SW] ? SW'(-diff) : SW'(diff);
          state_r <= S_R1;
        end
        S_R1: begin
          sq_r    <= ad_r * ad_r;
          x0_r    <= rdata_r;
          state_r <= S_R2;
        end
        S_R2: begin
          acc_r   <= acc_r + oav_pkg::ACC_W'(sq_r);
          xm_r    <= rdata_r;
          state_r <= (t_r + 1'b1 == terms_r) ? S_DIVM : S_R3;
        end
        S_R3: begin
          // slide both clusters one sample forward
          sa_r    <= sa_r + SW'(xm_r) - SW'(x0_r);
          sb_r    <= sb_r + SW'(rdata_r) - SW'(xm_r);
          t_r     <= t_r + 1'b1;
          state_r <= S_SQ;
        end
        S_DIVM: begin
          mm_r    <= m_r * m_r;
          tau_r   <= 48'(44'(m_r) * 44'(period_r));
          state_r <= S_DIVD;
        end
        S_DIVD: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            var_r <= div_q;
            if (div_q[63:48] != '0) begin
              dev_r   <= '1;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_SQRTW;
            end
          end
        end
        S_SQRTW: begin
          if (sqrt_done) begin
            dev_r   <= sqrt_root;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r  <= '{kind: oav_pkg::KIND_POINT, cluster_size: m_r, tau: tau_r,
                             variance: var_r, deviation: dev_r, last_result: 1'b0};
            if (dev_r != '0 && (!found_r || dev_r < min_dev_r)) begin
              found_r   <= 1'b1;
              min_dev_r <= dev_r;
              tau_min_r <= tau_r;
            end
            i_r     <= i_r + 1'b1;
            m_r     <= {m_r[AW-2:0], 1'b0};
            state_r <= (i_r + 1'b1 == ntau_r) ? S_SUM : S_TAU;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_data_r  <= '{kind: oav_pkg::KIND_SUMMARY, cluster_size: '0,
                             tau: found_r ? tau_min_r : '0, variance: '0,
                             deviation: found_r ? min_dev_r : '0, last_result: 1'b1};
            count_r   <= '0;
            found_r   <= 1'b0;
            min_dev_r <= '1;
            tau_min_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_data_r  <= '{kind: oav_pkg::KIND_ERROR, cluster_size: '0, tau: '0,
                             variance: '0, deviation: '0, last_result: 1'b1};
            count_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(oav_pkg::MAX_SAMPLES))
    else $error("sample count past store depth");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_sample) |=> in_stall)
    else $error("input not stalled after last sample beat");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == oav_pkg::KIND_ERROR) |-> out_data.last_result)
    else $error("error result without last_result");

endmodule

[tb/overlapping_allan_variance_core_tb.sv]
// Self-checking bench for the overlapping Allan variance core: random and directed
// sample sets, an in-bench variance/deviation predictor and field-wise result compare.
// Depends on oav_pkg and the core RTL.
`timescale 1ns / 1ps
module overlapping_allan_variance_core_tb;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  oav_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  oav_pkg::out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [31:0] cfg_data;

  overlapping_allan_variance_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  oav_pkg::in_item_t  sample_queue[$];
  oav_pkg::out_item_t expected_points[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        in_taken;
  int        mismatches;
  int        results_seen;
  int        sets_run;
  int        beats_sent;

  // shadow state of the core
  logic signed [15:0] shadow_store[oav_pkg::MAX_SAMPLES];
  int          shadow_count;
  logic [4:0]  shadow_tau_limit;
  logic [31:0] shadow_period;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic oav_pkg::out_item_t make_point(logic [1:0] kind, logic [11:0] m,
                                                    logic [47:0] tau, logic [63:0] var_v,
                                                    logic [31:0] dev, logic last);
    oav_pkg::out_item_t r;
    r.kind = kind;
    r.cluster_size = m;
    r.tau = tau;
    r.variance = var_v;
    r.deviation = dev;
    r.last_result = last;
    return r;
  endfunction

  // predicts every result of a finished data set
  task automatic predict_allan_set();
    int          n, m_max, n_tau, lim, m, terms;
    longint      sa, sb, diff;
    logic [127:0] acc, quot, divisor;
    logic [63:0] var_v, dev, tau;
    logic [31:0] min_dev;
    logic [47:0] min_tau;
    bit          found;
    n = shadow_count;
    if (n < oav_pkg::MIN_SAMPLES) begin
      expected_points.push_back(make_point(oav_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b1));
      return;
    end
    lim = (shadow_tau_limit < 2) ? 2 : shadow_tau_limit;
    m_max = n / 3;
    if (m_max < 2) m_max = 2;
    n_tau = lim;
    if (n_tau > m_max) n_tau = m_max;
    if (n_tau > oav_pkg::MAX_TAU) n_tau = oav_pkg::MAX_TAU;
    found = 0;
    min_dev = '1;
    min_tau = 0;
    m = 1;
    for (int i = 0; i < n_tau; i++) begin
      if (m > m_max) m = m_max;
      terms = n - 2 * m + 1;
      sa = 0;
      sb = 0;
      for (int j = 0; j < m; j++) begin
        sa += shadow_store[j];
        sb += shadow_store[m + j];
      end
      acc = 0;
      for (int t = 0; t < terms; t++) begin
        diff = sb - sa;
        acc += 128'(diff * diff);
        if (t + 1 < terms) begin
          sa += shadow_store[t + m] - shadow_store[t];
          sb += shadow_store[t + 2 * m] - shadow_store[t + m];
        end
      end
      divisor = 128'(2 * longint'(m) * longint'(m) * longint'(terms));
      quot = (acc << 16) / divisor;
      var_v = (quot[127:64] != 0) ? '1 : quot[63:0];
      if (var_v >= (64'd1 << 48)) dev = 64'hFFFF_FFFF;
      else dev = int_sqrt(var_v << 16);
      tau = (64'(m) * 64'(shadow_period)) & 64'hFFFF_FFFF_FFFF;
      if (dev > 0 && (!found || dev[31:0] < min_dev)) begin
        found = 1;
        min_dev = dev[31:0];
        min_tau = tau[47:0];
      end
      expected_points.push_back(make_point(oav_pkg::KIND_POINT, m[11:0], tau[47:0], var_v,
                                           dev[31:0], 1'b0));
      m = m * 2;
    end
    if (found) begin
      expected_points.push_back(make_point(oav_pkg::KIND_SUMMARY, '0, min_tau, '0, min_dev,
                                           1'b1));
    end else begin
      expected_points.push_back(make_point(oav_pkg::KIND_SUMMARY, '0, '0, '0, '0, 1'b1));
    end
  endtask

  // input beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: shadow the store on input beats, check result beats
  always @(posedge clk) begin
    oav_pkg::out_item_t exp_r;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      beats_sent++;
      if (shadow_count < oav_pkg::MAX_SAMPLES) begin
        shadow_store[shadow_count] = in_data.sample;
        shadow_count++;
      end
      if (in_data.last_sample) begin
        predict_allan_set();
        shadow_count = 0;
        sets_run++;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        exp_r = expected_points.pop_front();
        if (out_data.kind !== exp_r.kind || out_data.cluster_size !== exp_r.cluster_size ||
            out_data.tau !== exp_r.tau || out_data.variance !== exp_r.variance ||
            out_data.deviation !== exp_r.deviation ||
            out_data.last_result !== exp_r.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", exp_r, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == oav_pkg::CFG_TAU_LIMIT) shadow_tau_limit = value[4:0];
    else shadow_period = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic push_beat(logic signed [15:0] s, logic last);
    oav_pkg::in_item_t it;
    it.sample = s;
    it.last_sample = last;
    sample_queue.push_back(it);
  endtask

  // one data set of random length and content style
  task automatic push_random_set(ref int count);
    int len, style, pick;
    logic signed [15:0] base;
    pick = $urandom_range(99);
    if (pick < 12) len = $urandom_range(1, 3);
    else if (pick < 90) len = $urandom_range(4, 30);
    else len = $urandom_range(31, 120);
    style = $urandom_range(3);
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: push_beat(16'($urandom), i == len - 1);
        1: push_beat(base + $signed(16'($urandom_range(0, 15)) - 16'sd8), i == len - 1);
        2: push_beat(base, i == len - 1);
        default: push_beat($urandom_range(1) ? 16'sh7FFF : 16'sh8000, i == len - 1);
      endcase
    end
    count += len;
  endtask

  initial begin
    int items;
    bit held;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = oav_pkg::CFG_TAU_LIMIT;
    cfg_data = '0;
    in_taken = 0;
    mismatches = 0;
    results_seen = 0;
    sets_run = 0;
    beats_sent = 0;
    shadow_count = 0;
    shadow_tau_limit = 5'd16;
    shadow_period = 32'h0001_0000;
    send_idle_pct = 6;
    recv_idle_pct = 50;
    held = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    write_reg(oav_pkg::CFG_TAU_LIMIT, 32'd16);
    write_reg(oav_pkg::CFG_PERIOD, 32'h0001_0000);
    // too few samples: one, two and three
    push_beat(16'sh8000, 1'b1);
    push_beat(16'sh7FFF, 1'b0);
    push_beat(16'sh8000, 1'b1);
    push_beat(16'sd0, 1'b0);
    push_beat(-16'sd1, 1'b0);
    push_beat(16'sd1, 1'b1);
    // flat data: no positive deviation
    for (int i = 0; i < 4; i++) push_beat(16'sh7FFF, i == 3);
    // full-scale square wave: full-scale differences at cluster size one
    for (int i = 0; i < 12; i++) push_beat(i[0] ? 16'sh7FFF : 16'sh8000, i == 11);
    wait_drained();
    repeat (400) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 6 : 0;
      case (phase)
        0: begin
          write_reg(oav_pkg::CFG_TAU_LIMIT, 32'd2);
          write_reg(oav_pkg::CFG_PERIOD, 32'd1);
        end
        1: begin
          write_reg(oav_pkg::CFG_TAU_LIMIT, 32'd7);
          write_reg(oav_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(oav_pkg::CFG_TAU_LIMIT, 32'd16);
          write_reg(oav_pkg::CFG_PERIOD, {16'($urandom_range(1, 65535)), 16'($urandom)});
        end
      endcase
      items = 0;
      while (items < 55) begin
        push_random_set(items);
        // hold back new beats until the core has delivered everything
        if (phase == 1 && !held && items > 20) begin
          wait_drained();
          held = 1;
        end
      end
      wait_drained();
      repeat (400) @(posedge clk);
    end

    $display("covered %0d data sets, %0d input beats, %0d result beats", sets_run, beats_sent,
             results_seen);
    $display("tau limits 2..16, sample periods 1 to full scale, short and flat sets included");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
